// ===== hdl/stlxc_pkg.sv =====
`default_nettype none

package stlxc_pkg;

	// number of registers that run side by side, one per seed word
	localparam int LFSR_COUNT   = 4;
	// result words per seed
	localparam int OUTPUT_WORDS = 2;

	// lane and merge control, driven by the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} stlxc_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/stlxc_lane.sv =====
`default_nettype none

module stlxc_lane #(
	parameter int LFSR_WIDTH = 32
) (
	input  wire                         clk,
	input  wire stlxc_pkg::stlxc_ctrl_t ctrl,
	input  wire logic [LFSR_WIDTH-1:0]  seed,
	output logic                        bit_out
);

	import stlxc_pkg::*;

	logic [LFSR_WIDTH-1:0] state_q;
	logic [LFSR_WIDTH-1:0] tap_q;

	// seed is both the start state and the tap mask
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			state_q <= seed;
			tap_q   <= seed;
		end else if (ctrl.step) begin
			state_q <= {^(state_q & tap_q), state_q[LFSR_WIDTH-1:1]};
		end
	end

	assign bit_out = state_q[0];

endmodule

`default_nettype wire

// ===== hdl/stlxc_merge.sv =====
`default_nettype none

module stlxc_merge #(
	parameter int TOTAL_BITS = 128,
	parameter int LANES      = 4
) (
	input  wire                         clk,
	input  wire stlxc_pkg::stlxc_ctrl_t ctrl,
	input  wire logic [LANES-1:0]       lane_bits,
	output logic [TOTAL_BITS-1:0]       acc
);

	import stlxc_pkg::*;

	logic [TOTAL_BITS-1:0] acc_q;

	// shift in at the top, so the first bit lands at bit 0 after a full run
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= '0;
		end else if (ctrl.step) begin
			acc_q <= {^lane_bits, acc_q[TOTAL_BITS-1:1]};
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ===== hdl/self_tapped_lfsr_xor_combiner.sv =====
`default_nettype none
// out_valid rises after the accepted seed is stepped through the lane
// registers, one bit per step, and the result reaches the output register.
// A new seed is taken only after that handoff, which waits on out_stall.
// A finished result waits in the output register while the next seed runs.
// Reset (arst_n, asynchronous, active low) clears the sequencer and the
// output valid; the data registers are not reset.

module self_tapped_lfsr_xor_combiner #(
	parameter int LFSR_WIDTH = 32,
	parameter int WORD_BITS  = 64
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire logic [LFSR_WIDTH-1:0]  seed_word0,
	input  wire logic [LFSR_WIDTH-1:0]  seed_word1,
	input  wire logic [LFSR_WIDTH-1:0]  seed_word2,
	input  wire logic [LFSR_WIDTH-1:0]  seed_word3,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [WORD_BITS-1:0]        stream_low,
	output logic [WORD_BITS-1:0]        stream_high
);

	import stlxc_pkg::*;

	localparam int TOTAL_BITS = WORD_BITS * OUTPUT_WORDS;
	localparam int CNT_W      = $clog2(TOTAL_BITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;
	logic [TOTAL_BITS-1:0] out_q;

	stlxc_ctrl_t           ctrl;
	logic [LFSR_WIDTH-1:0] seeds [LFSR_COUNT];
	logic [LFSR_COUNT-1:0] lane_bits;
	logic [TOTAL_BITS-1:0] acc;
	logic                  out_free;
	logic                  last_step;

	assign seeds[0] = seed_word0;
	assign seeds[1] = seed_word1;
	assign seeds[2] = seed_word2;
	assign seeds[3] = seed_word3;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign last_step = (cnt_q == CNT_W'(TOTAL_BITS - 1));

	assign ctrl.load = (state_q == ST_IDLE) && in_valid;
	assign ctrl.step = (state_q == ST_RUN);

	for (genvar i = 0; i < LFSR_COUNT; i++) begin : g_lane
		stlxc_lane #(
			.LFSR_WIDTH(LFSR_WIDTH)
		) u_lane (
			.clk     (clk),
			.ctrl    (ctrl),
			.seed    (seeds[i]),
			.bit_out (lane_bits[i])
		);
	end

	stlxc_merge #(
		.TOTAL_BITS(TOTAL_BITS),
		.LANES     (LFSR_COUNT)
	) u_merge (
		.clk       (clk),
		.ctrl      (ctrl),
		.lane_bits (lane_bits),
		.acc       (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= acc;
		end
	end

	assign out_valid   = out_valid_q;
	assign stream_low  = out_q[WORD_BITS-1:0];
	assign stream_high = out_q[TOTAL_BITS-1:WORD_BITS];

endmodule

`default_nettype wire
